/* sv/compass_vector_polar_converter_assert.svh */
// Assertion macros shared by the converter RTL files.
`ifndef COMPASS_VECTOR_POLAR_CONVERTER_ASSERT_SVH
`define COMPASS_VECTOR_POLAR_CONVERTER_ASSERT_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define CVP_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off during reset.
`define CVP_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/cvp_pkg.sv */
// Types, constants and the arctangent table of the vector polar converter.
package cvp_pkg;

  // Datapath sizes
  localparam int CVP_CORDIC_STEPS = 16;  // default micro-rotation count
  localparam int CVP_ATAN_ENTRIES = 24;  // arctangent table depth
  localparam int CVP_SQRT_STEPS   = 16;  // one root bit per step
  localparam int CVP_DW           = 36;  // CORDIC component width, 16 fraction bits
  localparam int CVP_ZW           = 32;  // angle width, fraction of a turn
  localparam int CVP_SQ_W         = 32;  // sum of squares / remainder width

  // 1/K gain compensation in Q30
  localparam logic [29:0] CVP_INV_GAIN = 30'd652032874;

  typedef enum logic {
    OP_TO_POLAR = 1'b0,
    OP_TO_CART  = 1'b1
  } op_e;

  // Request: one conversion
  typedef struct packed {
    op_e                op;
    logic signed [15:0] x_in;
    logic signed [15:0] y_in;
    logic [15:0]        bearing_in;
    logic [15:0]        length_in;
  } req_t;

  // Result of one conversion
  typedef struct packed {
    logic signed [15:0] x_out;
    logic signed [15:0] y_out;
    logic [15:0]        bearing_out;
    logic [15:0]        length_out;
    logic               clipped;
  } rsp_t;

  // Working state carried down the step pipeline
  typedef struct packed {
    req_t                      req;
    logic                      zero;
    logic signed [CVP_DW-1:0]  u;
    logic signed [CVP_DW-1:0]  v;
    logic [CVP_ZW-1:0]         z;
    logic [CVP_SQ_W-1:0]       rem;
    logic [CVP_SQ_W-1:0]       root;
  } stage_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [CVP_ZW-1:0] atan_turn(input logic [4:0] idx);
    logic [CVP_ZW-1:0] a;
    case (idx)
      5'd0:    a = 32'd536870912;
      5'd1:    a = 32'd316933406;
      5'd2:    a = 32'd167458907;
      5'd3:    a = 32'd85004756;
      5'd4:    a = 32'd42667331;
      5'd5:    a = 32'd21354465;
      5'd6:    a = 32'd10679838;
      5'd7:    a = 32'd5340245;
      5'd8:    a = 32'd2670163;
      5'd9:    a = 32'd1335087;
      5'd10:   a = 32'd667544;
      5'd11:   a = 32'd333772;
      5'd12:   a = 32'd166886;
      5'd13:   a = 32'd83443;
      5'd14:   a = 32'd41722;
      5'd15:   a = 32'd20861;
      5'd16:   a = 32'd10430;
      5'd17:   a = 32'd5215;
      5'd18:   a = 32'd2608;
      5'd19:   a = 32'd1304;
      5'd20:   a = 32'd652;
      5'd21:   a = 32'd326;
      5'd22:   a = 32'd163;
      5'd23:   a = 32'd81;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

/* sv/compass_vector_polar_converter.sv */
// Top level of the pipelined Cartesian / compass polar vector converter.
//
// Input channel: in_valid_i, in_stall_o, in_req_i. A request is taken at a
// clock edge with in_valid_i high and in_stall_o low. op picks the direction:
// to polar uses x_in and y_in, to Cartesian uses bearing_in and length_in.
// Output channel: out_valid_o, out_stall_i, out_rsp_o; one result per request,
// in request order. Bearings are 65536 units per turn, clockwise from +y.
// The pipeline is two front stages (multipliers, start values), NS step stages
// with NS = max(NE, 16), NE = min(CORDIC_STEPS, 24), one rounding stage and the
// output buffer. One request enters per cycle while in_stall_o is low.
// Step stage k runs a CORDIC micro-rotation if k < NE and a root bit if k < 16.
// A two-entry output buffer sits behind the pipeline; in_stall_o rises when
// both entries hold results, and then the whole pipeline holds its contents.
// Reset clears all valid bits and the buffer; the block is ready right away.
module compass_vector_polar_converter #(
  parameter int CORDIC_STEPS = cvp_pkg::CVP_CORDIC_STEPS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  cvp_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output cvp_pkg::rsp_t out_rsp_o
);
  import cvp_pkg::*;

  `include "compass_vector_polar_converter_assert.svh"

  localparam int NE = (CORDIC_STEPS < CVP_ATAN_ENTRIES) ? CORDIC_STEPS : CVP_ATAN_ENTRIES;
  localparam int NS = (NE > CVP_SQRT_STEPS) ? NE : CVP_SQRT_STEPS;

  logic   en;
  logic   full;
  logic   st_valid [0:NS];
  stage_t st_data  [0:NS];
  logic   fin_valid;
  rsp_t   fin_rsp;

  // Pipeline advances whenever the output buffer has room
  assign en         = !full;
  assign in_stall_o = full;

  cvp_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .req_i   (in_req_i),
    .valid_o (st_valid[0]),
    .data_o  (st_data[0])
  );

  // Step stages
  for (genvar k = 0; k < NS; k++) begin : g_step
    cvp_stage #(
      .IDX     (k),
      .DO_ROT  (k < NE),
      .DO_SQRT (k < CVP_SQRT_STEPS)
    ) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (st_valid[k]),
      .data_i  (st_data[k]),
      .valid_o (st_valid[k+1]),
      .data_o  (st_data[k+1])
    );
  end

  cvp_finish u_finish (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (st_valid[NS]),
    .data_i  (st_data[NS]),
    .valid_o (fin_valid),
    .rsp_o   (fin_rsp)
  );

  cvp_skid u_skid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fin_valid && en),
    .rsp_i   (fin_rsp),
    .full_o  (full),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .rsp_o   (out_rsp_o)
  );

  `CVP_ASSERT_IMPL(a_stall_has_result, in_stall_o, out_valid_o, "input stalled with no result")
  `CVP_ASSERT_NEXT(a_pop_frees_input, out_valid_o && !out_stall_i, !in_stall_o, "input stalled after result taken")

endmodule

/* sv/cvp_prep.sv */
// Front end: squares and gain product, then CORDIC and root start values.
module cvp_prep (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  cvp_pkg::req_t req_i,
  output logic          valid_o,
  output cvp_pkg::stage_t data_o
);
  import cvp_pkg::*;

  localparam int PL_W    = 46;               // 16 x 30 bit gain product
  localparam int GAIN_SH = 14;               // Q30 * integer -> Q16
  localparam int UG_W    = PL_W + 1 - GAIN_SH;

  typedef struct packed {
    req_t               req;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic [PL_W-1:0]    pl;
  } prod_t;

  logic               a_valid_q;
  prod_t              a_d, a_q;
  logic               b_valid_q;
  stage_t             b_d, b_q;
  logic signed [15:0] x_s, y_s;
  logic [PL_W:0]      pl_rnd;
  logic [UG_W-1:0]    ug;
  logic signed [CVP_DW-1:0] u_p, v_p, u_c;
  logic               flip;
  logic [15:0]        b_adj;

  // Stage A: multipliers
  always_comb begin
    x_s    = req_i.x_in;
    y_s    = req_i.y_in;
    a_d.req = req_i;
    a_d.px  = x_s * x_s;
    a_d.py  = y_s * y_s;
    a_d.pl  = PL_W'(req_i.length_in) * PL_W'(CVP_INV_GAIN);
  end

  // Stage B: start values for both modes
  always_comb begin
    pl_rnd = {1'b0, a_q.pl} + (PL_W + 1)'(1 << (GAIN_SH - 1));
    ug     = pl_rnd[PL_W:GAIN_SH];
    u_c    = CVP_DW'(ug);
    u_p    = {{(CVP_DW - 32){a_q.req.y_in[15]}}, a_q.req.y_in, 16'h0000};
    v_p    = {{(CVP_DW - 32){a_q.req.x_in[15]}}, a_q.req.x_in, 16'h0000};
    // bearings from a quarter to three quarters start from -y
    flip   = a_q.req.bearing_in[15] ^ a_q.req.bearing_in[14];
    b_adj  = {a_q.req.bearing_in[15] ^ flip, a_q.req.bearing_in[14:0]};

    b_d.req  = a_q.req;
    b_d.zero = (a_q.req.x_in == 16'sd0) && (a_q.req.y_in == 16'sd0);
    b_d.rem  = CVP_SQ_W'(a_q.px) + CVP_SQ_W'(a_q.py);
    b_d.root = '0;
    if (a_q.req.op == OP_TO_POLAR) begin
      // lower half plane: turn by half a turn first
      b_d.u = a_q.req.y_in[15] ? -u_p : u_p;
      b_d.v = a_q.req.y_in[15] ? -v_p : v_p;
      b_d.z = a_q.req.y_in[15] ? {1'b1, {(CVP_ZW - 1){1'b0}}} : '0;
    end else begin
      b_d.u = flip ? -u_c : u_c;
      b_d.v = '0;
      b_d.z = {b_adj, 16'h0000};
    end
  end

  // Pipeline registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else if (en_i) begin
      a_valid_q <= valid_i;
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q <= a_d;
      b_q <= b_d;
    end
  end

  assign valid_o = b_valid_q;
  assign data_o  = b_q;

endmodule

/* sv/cvp_stage.sv */
// One pipeline step: a CORDIC micro-rotation and/or one square root bit, per DO_ROT and DO_SQRT.
module cvp_stage #(
  parameter int IDX     = 0,
  parameter bit DO_ROT  = 1'b1,
  parameter bit DO_SQRT = 1'b1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  cvp_pkg::stage_t data_i,
  output logic            valid_o,
  output cvp_pkg::stage_t data_o
);
  import cvp_pkg::*;

  localparam int                SQ_SH  = DO_SQRT ? (CVP_SQ_W - 2 - 2 * IDX) : 0;
  localparam logic [CVP_SQ_W-1:0] SQ_BIT = CVP_SQ_W'(1) << SQ_SH;
  localparam logic [CVP_ZW-1:0]   ATAN   = atan_turn(5'(IDX));

  logic                     valid_q;
  stage_t                   data_d, data_q;
  logic signed [CVP_DW-1:0] u, v, u_sh, v_sh;
  logic                     dir;
  logic [CVP_SQ_W:0]        trial;

  always_comb begin
    data_d = data_i;
    u      = data_i.u;
    v      = data_i.v;
    u_sh   = u >>> IDX;
    v_sh   = v >>> IDX;
    // vectoring drives v to zero, rotation drives the residual angle to zero
    dir    = (data_i.req.op == OP_TO_POLAR) ? ~v[CVP_DW-1] : data_i.z[CVP_ZW-1];
    trial  = {1'b0, data_i.root} + {1'b0, SQ_BIT};

    if (DO_ROT) begin
      if (dir) begin
        data_d.u = u + v_sh;
        data_d.v = v - u_sh;
        data_d.z = data_i.z + ATAN;
      end else begin
        data_d.u = u - v_sh;
        data_d.v = v + u_sh;
        data_d.z = data_i.z - ATAN;
      end
    end

    // restoring square root, two remainder bits per step
    if (DO_SQRT) begin
      if ({1'b0, data_i.rem} >= trial) begin
        data_d.rem  = data_i.rem - trial[CVP_SQ_W-1:0];
        data_d.root = (data_i.root >> 1) + SQ_BIT;
      end else begin
        data_d.root = data_i.root >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* sv/cvp_finish.sv */
// Result stage: bearing and root rounding, component rounding and saturation.
module cvp_finish (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  cvp_pkg::stage_t data_i,
  output logic            valid_o,
  output cvp_pkg::rsp_t   rsp_o
);
  import cvp_pkg::*;

  localparam int RW = CVP_DW - 15;  // width after dropping 16 fraction bits

  logic        valid_q;
  rsp_t        rsp_d, rsp_q;
  logic [16:0] xs, ys;

  // round half up to an integer, saturate to 16 bits; msb is the clip flag
  function automatic logic [16:0] round_sat(input logic signed [CVP_DW-1:0] a);
    logic [CVP_DW:0] s;
    logic [RW-1:0]   r;
    logic [16:0]     res;
    s = {a[CVP_DW-1], a} + (CVP_DW + 1)'(1 << 15);
    r = s[CVP_DW:16];
    if (!r[RW-1] && (|r[RW-2:15])) begin
      res = {1'b1, 16'h7FFF};
    end else if (r[RW-1] && !(&r[RW-2:15])) begin
      res = {1'b1, 16'h8000};
    end else begin
      res = {1'b0, r[15:0]};
    end
    return res;
  endfunction

  always_comb begin
    xs = round_sat(data_i.v);
    ys = round_sat(data_i.u);
    if (data_i.req.op == OP_TO_POLAR) begin
      rsp_d.x_out       = data_i.req.x_in;
      rsp_d.y_out       = data_i.req.y_in;
      // zero vector points a quarter turn round
      rsp_d.bearing_out = data_i.zero ? 16'h4000
                        : data_i.z[31:16] + {15'b0, data_i.z[15]};
      rsp_d.length_out  = data_i.root[15:0] + 16'(data_i.rem > data_i.root);
      rsp_d.clipped     = 1'b0;
    end else begin
      rsp_d.x_out       = xs[15:0];
      rsp_d.y_out       = ys[15:0];
      rsp_d.bearing_out = data_i.req.bearing_in;
      rsp_d.length_out  = data_i.req.length_in;
      rsp_d.clipped     = xs[16] | ys[16];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rsp_q <= rsp_d;
    end
  end

  assign valid_o = valid_q;
  assign rsp_o   = rsp_q;

endmodule

/* sv/cvp_skid.sv */
// Two-entry output buffer; full stops the pipeline from a register.
module cvp_skid (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  cvp_pkg::rsp_t rsp_i,
  output logic          full_o,
  output logic          valid_o,
  input  logic          stall_i,
  output cvp_pkg::rsp_t rsp_o
);
  import cvp_pkg::*;

  `include "compass_vector_polar_converter_assert.svh"

  logic [1:0] count_q, count_d;
  rsp_t       head_q, head_d, spare_q, spare_d;
  logic       pop;

  assign pop = (count_q != 2'd0) && !stall_i;

  // Entry movement
  always_comb begin
    count_d = count_q;
    head_d  = head_q;
    spare_d = spare_q;
    if (push_i && !pop) begin
      count_d = count_q + 2'd1;
      if (count_q == 2'd0) begin
        head_d = rsp_i;
      end else begin
        spare_d = rsp_i;
      end
    end else if (pop && !push_i) begin
      count_d = count_q - 2'd1;
      head_d  = spare_q;
    end else if (push_i && pop) begin
      if (count_q == 2'd1) begin
        head_d = rsp_i;
      end else begin
        head_d  = spare_q;
        spare_d = rsp_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q  <= head_d;
    spare_q <= spare_d;
  end

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign rsp_o   = head_q;

  `CVP_ASSERT_IMPL(a_no_push_when_full, count_q == 2'd2, !push_i, "push into full buffer")
  `CVP_ASSERT_IMPL(a_count_range, 1'b1, count_q != 2'd3, "buffer count out of range")

endmodule
